[hdl/branch_target_buffer_lru_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the branch target buffer
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRANCH_TARGET_BUFFER_LRU_CORE_MACROS_SVH
`define BRANCH_TARGET_BUFFER_LRU_CORE_MACROS_SVH

// same-cycle implication
`define BTBL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btbl assertion failed");

// next-cycle implication
`define BTBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btbl assertion failed");

`endif

[hdl/btbl_pkg.sv]
// ----------------------------------------------------------------------------
// btbl_pkg
// Shared constants and types of the branch target buffer.
// ----------------------------------------------------------------------------
package btbl_pkg;

    localparam int unsigned ENTRIES_DEF   = 4;
    localparam int unsigned ADDR_BITS_DEF = 32;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned CNT_W   = 2;

    localparam int unsigned S_TDATA_W = ((2 * FIELD_W + 1 + 7) / 8) * 8;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = ((FIELD_W + CNT_W + 7) / 8) * 8;
    localparam int unsigned M_TUSER_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX  = 2'b11;
    localparam logic [CNT_W-1:0] CNT_ZERO = 2'b00;
    localparam logic [CNT_W-1:0] CNT_INIT = 2'b01;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

[hdl/btbl_ctrl.sv]
// ----------------------------------------------------------------------------
// btbl_ctrl
// Transaction sequencer: captures an input transaction, then commits it
// into the result register (and an update into the buffer) once that register is free.
// ----------------------------------------------------------------------------
`include "branch_target_buffer_lru_core_macros.svh"

module btbl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output btbl_pkg::t_dp_cmd o_cmd
);
    import btbl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_s_tready    = (r_state == ST_IDLE);
    assign o_m_tvalid    = r_out_valid;
    assign o_cmd.capture = i_s_tvalid && (r_state == ST_IDLE);
    assign o_cmd.commit  = (r_state == ST_CALC) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (o_cmd.commit) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `BTBL_ASSERT_NEXT(a_no_double_capture, o_cmd.capture, !o_cmd.capture)
    `BTBL_ASSERT_NEXT(a_stall_holds_calc, (r_state == ST_CALC) && r_out_valid && !i_m_tready, r_state == ST_CALC)
    `BTBL_ASSERT_NEXT(a_commit_fills_out, o_cmd.commit, r_out_valid)

endmodule

[hdl/btbl_dpath.sv]
// ----------------------------------------------------------------------------
// btbl_dpath
// Entry storage, parallel tag compare, victim selection, counter and rank
// update, and the result register.
// ----------------------------------------------------------------------------
`include "branch_target_buffer_lru_core_macros.svh"

module btbl_dpath #(
    parameter int unsigned ENTRIES   = btbl_pkg::ENTRIES_DEF,
    parameter int unsigned ADDR_BITS = btbl_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btbl_pkg::t_dp_cmd             i_cmd,
    input  logic                          i_op,
    input  logic [btbl_pkg::FIELD_W-1:0]  i_branch_addr,
    input  logic [btbl_pkg::FIELD_W-1:0]  i_target_addr,
    input  logic                          i_taken,
    output logic                          o_hit,
    output logic [btbl_pkg::FIELD_W-1:0]  o_predicted_target,
    output logic [btbl_pkg::CNT_W-1:0]    o_confidence
);
    import btbl_pkg::*;

    localparam int unsigned TAG_W = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int unsigned IW    = $clog2(ENTRIES);
    localparam int unsigned SW    = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]             r_valid;
    logic [TAG_W-1:0]               r_tag    [ENTRIES];
    logic [TAG_W-1:0]               r_tgt    [ENTRIES];
    logic [CNT_W-1:0]               r_cnt    [ENTRIES];
    logic [IW-1:0]                  r_rank   [ENTRIES];
    logic [SW-1:0]                  r_slots_used;

    logic                           r_op;
    logic [TAG_W-1:0]               r_addr;
    logic [TAG_W-1:0]               r_target;
    logic                           r_taken;

    logic                           r_hit;
    logic [FIELD_W-1:0]             r_pred;
    logic [CNT_W-1:0]               r_conf;

    logic [ENTRIES-1:0]             match_vec;
    logic [ENTRIES-1:0]             zero_vec;
    logic [ENTRIES-1:0]             rank0_vec;
    logic                           hit_any;
    logic [IW-1:0]                  victim;
    logic [IW-1:0]                  sel;
    logic [CNT_W-1:0]               old_cnt;
    logic [IW-1:0]                  old_rank;
    logic                           is_update;
    logic                           wr_hit;
    logic                           wr_alloc;
    logic                           wr_any;
    logic [CNT_W-1:0]               new_cnt;
    logic                           new_valid;
    logic                           append;
    logic [IW-1:0]                  top_rank;
    logic                           res_hit;
    logic [TAG_W-1:0]               res_tgt;
    logic [CNT_W-1:0]               res_cnt;

    function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] vec);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = r_valid[i] && (r_tag[i] == r_addr);
            zero_vec[i]  = (r_cnt[i] == CNT_ZERO);
            rank0_vec[i] = (r_rank[i] == '0);
        end
    end

    assign hit_any = |match_vec;

    always_comb begin
        if (!(&r_valid)) begin
            victim = first_set(~r_valid);
        end else if (|zero_vec) begin
            victim = first_set(zero_vec);
        end else begin
            victim = first_set(rank0_vec);
        end
    end

    assign sel       = hit_any ? first_set(match_vec) : victim;
    assign old_cnt   = r_cnt[sel];
    assign old_rank  = r_rank[sel];
    assign is_update = (r_op == OP_UPDATE);
    assign wr_hit    = is_update && hit_any;
    assign wr_alloc  = is_update && !hit_any && r_taken;
    assign wr_any    = wr_hit || wr_alloc;

    always_comb begin
        if (!wr_hit) begin
            new_cnt = CNT_INIT;
        end else if (r_taken) begin
            new_cnt = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + CNT_W'(1);
        end else begin
            new_cnt = (old_cnt == CNT_ZERO) ? CNT_ZERO : old_cnt - CNT_W'(1);
        end
    end

    assign new_valid = wr_alloc || r_taken || (new_cnt != CNT_ZERO);
    assign append    = wr_alloc && (SW'(sel) >= r_slots_used)
                       && (r_slots_used < SW'(ENTRIES));
    assign top_rank  = (r_slots_used == '0) ? '0 : IW'(r_slots_used - SW'(1));

    assign res_hit = is_update ? (wr_hit ? new_valid : wr_alloc) : hit_any;
    assign res_tgt = wr_alloc ? r_target : r_tgt[sel];
    assign res_cnt = is_update ? new_cnt : old_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_addr   <= i_branch_addr[TAG_W-1:0];
            r_target <= i_target_addr[TAG_W-1:0];
            r_taken  <= i_taken;
        end
        if (i_cmd.commit) begin
            r_hit  <= res_hit;
            r_pred <= res_hit ? FIELD_W'(res_tgt) : '0;
            r_conf <= res_hit ? res_cnt : CNT_ZERO;
        end
        if (i_cmd.commit && wr_alloc) begin
            r_tag[sel] <= r_addr;
            r_tgt[sel] <= r_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_slots_used <= '0;
            for (int j = 0; j < ENTRIES; j++) begin
                r_cnt[j]  <= CNT_ZERO;
                r_rank[j] <= '0;
            end
        end else if (i_cmd.commit && wr_any) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (IW'(j) == sel) begin
                    r_valid[j] <= new_valid;
                    r_cnt[j]   <= new_cnt;
                    r_rank[j]  <= append ? IW'(r_slots_used) : top_rank;
                end else if (!append && (SW'(j) < r_slots_used)
                             && (r_rank[j] > old_rank)) begin
                    r_rank[j] <= r_rank[j] - IW'(1);
                end
            end
            if (append) begin
                r_slots_used <= r_slots_used + SW'(1);
            end
        end
    end

    assign o_hit              = r_hit;
    assign o_predicted_target = r_pred;
    assign o_confidence       = r_conf;

    `BTBL_ASSERT_SAME(a_slots_bounded, 1'b1, r_slots_used <= SW'(ENTRIES))
    `BTBL_ASSERT_SAME(a_valid_within_used, 1'b1, $countones(r_valid) <= int'(r_slots_used))
    `BTBL_ASSERT_NEXT(a_lookup_keeps_state, i_cmd.commit && !is_update, $stable(r_valid) && $stable(r_slots_used))

endmodule

[hdl/branch_target_buffer_lru_core.sv]
// ----------------------------------------------------------------------------
// branch_target_buffer_lru_core
// Fully associative branch target buffer with 2-bit counters and LRU ranks.
// ----------------------------------------------------------------------------
// Each transaction is first captured; then its branch address is compared
// against all entries in parallel, a victim is picked, the entry is written
// back and the result register is loaded. A new transaction is accepted
// as soon as that write-back is done, also while the previous result still
// waits on the master side; the compare step waits only while the result
// register is still full. Lookups (tuser 0) leave the buffer unchanged;
// updates (tuser 1) train or allocate an entry, and their result reports the
// entry after the update. The buffer is usable right after reset.
// ----------------------------------------------------------------------------
module branch_target_buffer_lru_core #(
    parameter int unsigned ENTRIES   = btbl_pkg::ENTRIES_DEF,
    parameter int unsigned ADDR_BITS = btbl_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [btbl_pkg::S_TDATA_W-1:0] i_s_tdata,  // branch_addr, target_addr, taken
    input  logic [btbl_pkg::S_TUSER_W-1:0] i_s_tuser,  // op
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [btbl_pkg::M_TDATA_W-1:0] o_m_tdata,  // predicted_target, confidence
    output logic [btbl_pkg::M_TUSER_W-1:0] o_m_tuser   // hit
);
    import btbl_pkg::*;

    t_dp_cmd            cmd;
    logic               hit;
    logic [FIELD_W-1:0] predicted_target;
    logic [CNT_W-1:0]   confidence;

    btbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    btbl_dpath #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_op               (i_s_tuser[0]),
        .i_branch_addr      (i_s_tdata[FIELD_W-1:0]),
        .i_target_addr      (i_s_tdata[2*FIELD_W-1:FIELD_W]),
        .i_taken            (i_s_tdata[2*FIELD_W]),
        .o_hit              (hit),
        .o_predicted_target (predicted_target),
        .o_confidence       (confidence)
    );

    assign o_m_tdata = M_TDATA_W'({confidence, predicted_target});
    assign o_m_tuser = M_TUSER_W'(hit);

endmodule
